@@ rtl/joystick_calibrate_deadzone_map_defines.svh @@
// ---------------------------------------------------------------------------
// joystick_calibrate_deadzone_map_defines
// Assertion macros shared by the joystick calibrate and map RTL.
// ---------------------------------------------------------------------------
`ifndef JOYSTICK_CALIBRATE_DEADZONE_MAP_DEFINES_SVH
`define JOYSTICK_CALIBRATE_DEADZONE_MAP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define JCDM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define JCDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/jcdm_pkg.sv @@
// ---------------------------------------------------------------------------
// jcdm_pkg
// Types and constants of the joystick calibrate and deadzone map block.
// ---------------------------------------------------------------------------
`default_nettype none

package jcdm_pkg;

    localparam int ADC_BITS        = 12;
    localparam int REG_W           = 12;
    localparam int PCT_W           = 8;
    localparam int PCT_SCALE       = 100;
    localparam int CAL_SAMPLES_DEF = 120;
    localparam int CFG_IDX_W       = 2;

    localparam logic [REG_W-1:0] RST_DEFAULT_CENTER   = 12'd2048;
    localparam logic [REG_W-1:0] RST_DEFAULT_DEADZONE = 12'd200;
    localparam logic [REG_W-1:0] RST_CAL_DEADZONE     = 12'd100;
    localparam logic [REG_W-1:0] RST_ADC_FULL_SCALE   = 12'd4095;
    localparam logic [REG_W-1:0] RST_CENTER           = 12'd2048;

    typedef enum logic [1:0] {
        OP_MEASURE = 2'd0,
        OP_CAL     = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEFAULT_CENTER   = 2'd0,
        CFG_DEFAULT_DEADZONE = 2'd1,
        CFG_CAL_DEADZONE     = 2'd2,
        CFG_ADC_FULL_SCALE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL_ACC,
        ST_PREP,
        ST_LAUNCH,
        ST_WAIT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

@@ rtl/jcdm_div.sv @@
// ---------------------------------------------------------------------------
// jcdm_div
// Restoring serial divider, one quotient bit per cycle, pulse on done.
// ---------------------------------------------------------------------------
`default_nettype none

module jcdm_div #(
    parameter int DVD_W = 19,
    parameter int DVS_W = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             fits;

    always_comb begin
        rem_sh = {r_rem, r_q[DVD_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        fits   = ~diff[DVS_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], fits};
            r_rem <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

@@ rtl/joystick_calibrate_deadzone_map.sv @@
// ---------------------------------------------------------------------------
// joystick_calibrate_deadzone_map
// Joystick centre calibration and deadzone percent mapping.
// ---------------------------------------------------------------------------
// One item is taken at a time; o_in_stall stays high until its result beat
// has been placed in the output register, which waits while the previous
// result beat is held by i_out_stall. A measure item passes the PREP, LAUNCH
// and WAIT states for X and then Y, and skips the divider for an axis that
// lands in the dead band or has no span; the item that ends a calibration run
// divides the X and then the Y sum; other calibration items only add to the
// sums. One restoring divider (DVD_W = 19 at the default CAL_SAMPLES) yields
// one quotient bit per cycle while busy and serves X and then Y in turn, both
// for the percent scaling and for the centre mean. A new item is taken while
// the previous result beat still waits downstream.
`default_nettype none

module joystick_calibrate_deadzone_map #(
    parameter int CAL_SAMPLES = jcdm_pkg::CAL_SAMPLES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [jcdm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [jcdm_pkg::REG_W-1:0]          i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_opcode,
    input  wire logic [jcdm_pkg::ADC_BITS-1:0]       i_sample_x,
    input  wire logic [jcdm_pkg::ADC_BITS-1:0]       i_sample_y,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [jcdm_pkg::PCT_W-1:0]        o_x_percent,
    output logic signed [jcdm_pkg::PCT_W-1:0]        o_y_percent,
    output logic                                     o_calibrated,
    output logic [jcdm_pkg::REG_W-1:0]               o_center_x_out,
    output logic [jcdm_pkg::REG_W-1:0]               o_center_y_out
);

`include "joystick_calibrate_deadzone_map_defines.svh"

    localparam int AW    = jcdm_pkg::ADC_BITS;
    localparam int RW    = jcdm_pkg::REG_W;
    localparam int PW    = jcdm_pkg::PCT_W;
    localparam int SUM_W = AW + $clog2(CAL_SAMPLES);
    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int PRD_W = RW + 7;
    localparam int DVD_W = (SUM_W > PRD_W) ? SUM_W : PRD_W;
    localparam int DVS_W = (CNT_W > RW) ? CNT_W : RW;
    localparam int SW    = RW + 2;

    jcdm_pkg::t_state r_state, n_state;

    logic [1:0]        r_op,     n_op;
    logic [AW-1:0]     r_sx,     n_sx;
    logic [AW-1:0]     r_sy,     n_sy;
    logic              r_axis,   n_axis;
    logic [RW-1:0]     r_off,    n_off;
    logic [RW-1:0]     r_span,   n_span;
    logic              r_neg,    n_neg;
    logic              r_zero,   n_zero;
    logic [PW-1:0]     r_px,     n_px;
    logic [PW-1:0]     r_py,     n_py;

    logic [SUM_W-1:0]  r_sum_x,  n_sum_x;
    logic [SUM_W-1:0]  r_sum_y,  n_sum_y;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [RW-1:0]     r_cx,     n_cx;
    logic [RW-1:0]     r_cy,     n_cy;
    logic              r_cal_flag, n_cal_flag;

    logic [RW-1:0]     r_def_center;
    logic [RW-1:0]     r_def_dz;
    logic [RW-1:0]     r_cal_dz;
    logic [RW-1:0]     r_full_scale;

    logic              r_o_valid, n_o_valid;
    logic [PW-1:0]     r_o_x;
    logic [PW-1:0]     r_o_y;
    logic              r_o_cal;
    logic [RW-1:0]     r_o_cx;
    logic [RW-1:0]     r_o_cy;
    logic              load_out;

    logic              div_start;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;

    logic              in_accept;
    logic              is_measure;
    logic [AW-1:0]     m_v;
    logic [RW-1:0]     m_c;
    logic [RW-1:0]     m_d;
    logic signed [SW-1:0] s_v, s_c, s_d, s_f, s_lo, s_hi, s_up;
    logic              below;
    logic              in_band;
    logic signed [SW-1:0] span_raw;
    logic signed [SW-1:0] off_raw;
    logic [6:0]        q_pct;
    logic [PW-1:0]     mag;
    logic [PW-1:0]     pct_val;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != jcdm_pkg::ST_IDLE);
    assign is_measure = (r_op == jcdm_pkg::OP_MEASURE);

    // one axis of the band classification
    always_comb begin
        m_v      = r_axis ? r_sy : r_sx;
        m_c      = r_cal_flag ? (r_axis ? r_cy : r_cx) : r_def_center;
        m_d      = r_cal_flag ? r_cal_dz : r_def_dz;
        s_v      = $signed(SW'(m_v));
        s_c      = $signed(SW'(m_c));
        s_d      = $signed(SW'(m_d));
        s_f      = $signed(SW'(r_full_scale));
        s_lo     = s_c - s_d;
        s_hi     = s_c + s_d;
        s_up     = s_f - s_c - s_d;
        below    = (s_v < s_c);
        in_band  = (s_v >= s_lo) && (s_v <= s_hi);
        span_raw = below ? s_lo : s_up;
        off_raw  = below ? (s_lo - s_v) : (s_v - s_hi);
    end

    // clamp, then sign: Y is inverted
    always_comb begin
        q_pct   = (div_q > DVD_W'(jcdm_pkg::PCT_SCALE)) ? 7'(jcdm_pkg::PCT_SCALE)
                                                         : div_q[6:0];
        mag     = {1'b0, q_pct};
        pct_val = (r_neg ^ r_axis) ? (~mag + 1'b1) : mag;
    end

    always_comb begin
        div_dividend = is_measure ? (DVD_W'(r_off) * DVD_W'(jcdm_pkg::PCT_SCALE))
                                  : (r_axis ? DVD_W'(r_sum_y) : DVD_W'(r_sum_x));
        div_divisor  = is_measure ? DVS_W'(r_span) : DVS_W'(CAL_SAMPLES);
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_axis     = r_axis;
        n_off      = r_off;
        n_span     = r_span;
        n_neg      = r_neg;
        n_zero     = r_zero;
        n_px       = r_px;
        n_py       = r_py;
        n_sum_x    = r_sum_x;
        n_sum_y    = r_sum_y;
        n_count    = r_count;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_cal_flag = r_cal_flag;
        div_start  = 1'b0;
        load_out   = 1'b0;
        n_o_valid  = r_o_valid && i_out_stall;

        case (r_state)
            jcdm_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_op   = i_opcode;
                    n_sx   = i_sample_x;
                    n_sy   = i_sample_y;
                    n_axis = 1'b0;
                    n_px   = '0;
                    n_py   = '0;
                    case (i_opcode)
                        jcdm_pkg::OP_MEASURE: n_state = jcdm_pkg::ST_PREP;
                        jcdm_pkg::OP_CAL:     n_state = jcdm_pkg::ST_CAL_ACC;
                        jcdm_pkg::OP_RESTART: begin
                            n_sum_x = '0;
                            n_sum_y = '0;
                            n_count = '0;
                            n_state = jcdm_pkg::ST_DONE;
                        end
                        default: n_state = jcdm_pkg::ST_DONE;
                    endcase
                end
            end
            jcdm_pkg::ST_CAL_ACC: begin
                n_sum_x = r_sum_x + SUM_W'(r_sx);
                n_sum_y = r_sum_y + SUM_W'(r_sy);
                if (r_count == CNT_W'(CAL_SAMPLES - 1)) begin
                    n_count = '0;
                    n_state = jcdm_pkg::ST_LAUNCH;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = jcdm_pkg::ST_DONE;
                end
            end
            jcdm_pkg::ST_PREP: begin
                n_off   = off_raw[RW-1:0];
                n_span  = span_raw[RW-1:0];
                n_neg   = below;
                n_zero  = in_band || (span_raw <= 0);
                n_state = jcdm_pkg::ST_LAUNCH;
            end
            jcdm_pkg::ST_LAUNCH: begin
                if (is_measure && r_zero) begin
                    if (r_axis) begin
                        n_state = jcdm_pkg::ST_DONE;
                    end else begin
                        n_axis  = 1'b1;
                        n_state = jcdm_pkg::ST_PREP;
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = jcdm_pkg::ST_WAIT;
                end
            end
            jcdm_pkg::ST_WAIT: begin
                if (div_done) begin
                    if (is_measure) begin
                        if (r_axis) begin
                            n_py    = pct_val;
                            n_state = jcdm_pkg::ST_DONE;
                        end else begin
                            n_px    = pct_val;
                            n_axis  = 1'b1;
                            n_state = jcdm_pkg::ST_PREP;
                        end
                    end else begin
                        if (r_axis) begin
                            n_cy       = div_q[RW-1:0];
                            n_cal_flag = 1'b1;
                            n_sum_x    = '0;
                            n_sum_y    = '0;
                            n_state    = jcdm_pkg::ST_DONE;
                        end else begin
                            n_cx    = div_q[RW-1:0];
                            n_axis  = 1'b1;
                            n_state = jcdm_pkg::ST_LAUNCH;
                        end
                    end
                end
            end
            jcdm_pkg::ST_DONE: begin
                if (!r_o_valid || !i_out_stall) begin
                    load_out  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = jcdm_pkg::ST_IDLE;
                end
            end
            default: n_state = jcdm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= jcdm_pkg::ST_IDLE;
            r_o_valid  <= 1'b0;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_count    <= '0;
            r_cx       <= jcdm_pkg::RST_CENTER;
            r_cy       <= jcdm_pkg::RST_CENTER;
            r_cal_flag <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_o_valid  <= n_o_valid;
            r_sum_x    <= n_sum_x;
            r_sum_y    <= n_sum_y;
            r_count    <= n_count;
            r_cx       <= n_cx;
            r_cy       <= n_cy;
            r_cal_flag <= n_cal_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_center <= jcdm_pkg::RST_DEFAULT_CENTER;
            r_def_dz     <= jcdm_pkg::RST_DEFAULT_DEADZONE;
            r_cal_dz     <= jcdm_pkg::RST_CAL_DEADZONE;
            r_full_scale <= jcdm_pkg::RST_ADC_FULL_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                jcdm_pkg::CFG_DEFAULT_CENTER:   r_def_center <= i_cfg_data;
                jcdm_pkg::CFG_DEFAULT_DEADZONE: r_def_dz     <= i_cfg_data;
                jcdm_pkg::CFG_CAL_DEADZONE:     r_cal_dz     <= i_cfg_data;
                jcdm_pkg::CFG_ADC_FULL_SCALE:   r_full_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_axis <= n_axis;
        r_off  <= n_off;
        r_span <= n_span;
        r_neg  <= n_neg;
        r_zero <= n_zero;
        r_px   <= n_px;
        r_py   <= n_py;
        if (load_out) begin
            r_o_x   <= r_px;
            r_o_y   <= r_py;
            r_o_cal <= r_cal_flag;
            r_o_cx  <= r_cx;
            r_o_cy  <= r_cy;
        end
    end

    jcdm_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_out_valid    = r_o_valid;
    assign o_x_percent    = $signed(r_o_x);
    assign o_y_percent    = $signed(r_o_y);
    assign o_calibrated   = r_o_cal;
    assign o_center_x_out = r_o_cx;
    assign o_center_y_out = r_o_cy;

    `JCDM_ASSERT_NOW(a_done_in_wait, div_done, r_state == jcdm_pkg::ST_WAIT,
        "divider finished outside the wait state")
    `JCDM_ASSERT_NOW(a_count_range, 1'b1, r_count < CNT_W'(CAL_SAMPLES),
        "calibration count reached the run length")
    `JCDM_ASSERT_NEXT(a_flag_sticky, r_cal_flag, r_cal_flag,
        "calibrated flag dropped")
    `JCDM_ASSERT_NOW(a_pct_range, o_out_valid,
        (o_x_percent >= -8'sd100) && (o_x_percent <= 8'sd100) &&
        (o_y_percent >= -8'sd100) && (o_y_percent <= 8'sd100),
        "percent outside -100..100")

endmodule

`default_nettype wire

@@ sim/tb_joystick_calibrate_deadzone_map.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_joystick_calibrate_deadzone_map
// Self-checking bench for the joystick calibrate and deadzone map block.
// Items go in over a valid/stall channel. Each one is run through a local
// model of the centre sums, the calibrated centres and the percent
// mapping. Every result beat is compared field by field, in order, with the
// model's output. Directed corner cases come first. Random phases follow,
// each with its own register settings and throttling: full and partial
// calibration runs, measure beats around the dead band and stray opcodes.
// ---------------------------------------------------------------------------
module tb_joystick_calibrate_deadzone_map;

    localparam int CAL_RUN = jcdm_pkg::CAL_SAMPLES_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int FULL = (1 << jcdm_pkg::ADC_BITS) - 1;

    typedef struct {
        logic signed [jcdm_pkg::PCT_W-1:0] x_pct;
        logic signed [jcdm_pkg::PCT_W-1:0] y_pct;
        logic cal;
        logic [jcdm_pkg::REG_W-1:0] cx;
        logic [jcdm_pkg::REG_W-1:0] cy;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [jcdm_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [jcdm_pkg::REG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_opcode = '0;
    logic [jcdm_pkg::ADC_BITS-1:0] i_sample_x = '0;
    logic [jcdm_pkg::ADC_BITS-1:0] i_sample_y = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [jcdm_pkg::PCT_W-1:0] o_x_percent;
    logic signed [jcdm_pkg::PCT_W-1:0] o_y_percent;
    logic o_calibrated;
    logic [jcdm_pkg::REG_W-1:0] o_center_x_out;
    logic [jcdm_pkg::REG_W-1:0] o_center_y_out;

    // model state and register copies
    int acc_x, acc_y, acc_count;
    int center_x = 2048, center_y = 2048;
    bit is_calibrated;
    int cfg_center = 2048, cfg_band = 200, cfg_cal_band = 100, cfg_full_scale = 4095;

    t_reading pending_readings[$];
    int send_idle_pct, recv_stall_pct;
    int mismatch_count, beats_checked, items_sent, measure_count, runs_completed;
    int cycle_count;

    joystick_calibrate_deadzone_map #(.CAL_SAMPLES(CAL_RUN)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_opcode(i_opcode),
        .i_sample_x(i_sample_x),
        .i_sample_y(i_sample_y),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_x_percent(o_x_percent),
        .o_y_percent(o_y_percent),
        .o_calibrated(o_calibrated),
        .o_center_x_out(o_center_x_out),
        .o_center_y_out(o_center_y_out)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats outstanding", cycle_count,
                pending_readings.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic int axis_percent(int v, int c, int d);
        int span;
        int p;
        if (v >= c - d && v <= c + d) return 0;
        if (v < c) begin
            span = c - d;
            if (span <= 0) return 0;
            p = -(((span - v) * jcdm_pkg::PCT_SCALE) / span);
        end else begin
            span = cfg_full_scale - c - d;
            if (span <= 0) return 0;
            p = ((v - c - d) * jcdm_pkg::PCT_SCALE) / span;
        end
        if (p > jcdm_pkg::PCT_SCALE) p = jcdm_pkg::PCT_SCALE;
        if (p < -jcdm_pkg::PCT_SCALE) p = -jcdm_pkg::PCT_SCALE;
        return p;
    endfunction

    function automatic t_reading track_and_map(logic [1:0] op, int sx, int sy);
        t_reading r;
        int px;
        int py;
        px = 0;
        py = 0;
        if (op == jcdm_pkg::OP_MEASURE) begin
            px = axis_percent(sx, is_calibrated ? center_x : cfg_center,
                is_calibrated ? cfg_cal_band : cfg_band);
            py = -axis_percent(sy, is_calibrated ? center_y : cfg_center,
                is_calibrated ? cfg_cal_band : cfg_band);
            measure_count++;
        end else if (op == jcdm_pkg::OP_CAL) begin
            acc_x += sx;
            acc_y += sy;
            acc_count++;
            if (acc_count >= CAL_RUN) begin
                center_x = (acc_x / CAL_RUN) & FULL;
                center_y = (acc_y / CAL_RUN) & FULL;
                is_calibrated = 1'b1;
                acc_x = 0;
                acc_y = 0;
                acc_count = 0;
                runs_completed++;
            end
        end else if (op == jcdm_pkg::OP_RESTART) begin
            acc_x = 0;
            acc_y = 0;
            acc_count = 0;
        end
        r.x_pct = px[jcdm_pkg::PCT_W-1:0];
        r.y_pct = py[jcdm_pkg::PCT_W-1:0];
        r.cal = is_calibrated;
        r.cx = center_x[jcdm_pkg::REG_W-1:0];
        r.cy = center_y[jcdm_pkg::REG_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_checked++;
            if (pending_readings.size() == 0) begin
                $error("result beat with no item outstanding");
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                if (o_x_percent !== want.x_pct) begin
                    $error("x_percent: expected %0d, got %0d", want.x_pct, o_x_percent);
                    mismatch_count++;
                end
                if (o_y_percent !== want.y_pct) begin
                    $error("y_percent: expected %0d, got %0d", want.y_pct, o_y_percent);
                    mismatch_count++;
                end
                if (o_calibrated !== want.cal) begin
                    $error("calibrated: expected %0d, got %0d", want.cal, o_calibrated);
                    mismatch_count++;
                end
                if (o_center_x_out !== want.cx) begin
                    $error("center_x_out: expected %0d, got %0d", want.cx, o_center_x_out);
                    mismatch_count++;
                end
                if (o_center_y_out !== want.cy) begin
                    $error("center_y_out: expected %0d, got %0d", want.cy, o_center_y_out);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input int sx, input int sy);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_sample_x <= sx[jcdm_pkg::ADC_BITS-1:0];
        i_sample_y <= sy[jcdm_pkg::ADC_BITS-1:0];
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        pending_readings.push_back(track_and_map(op, sx & FULL, sy & FULL));
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(input int dc, input int dd, input int cd, input int fs);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= jcdm_pkg::CFG_DEFAULT_CENTER;
        i_cfg_data <= dc[jcdm_pkg::REG_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= jcdm_pkg::CFG_DEFAULT_DEADZONE;
        i_cfg_data <= dd[jcdm_pkg::REG_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= jcdm_pkg::CFG_CAL_DEADZONE;
        i_cfg_data <= cd[jcdm_pkg::REG_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= jcdm_pkg::CFG_ADC_FULL_SCALE;
        i_cfg_data <= fs[jcdm_pkg::REG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_center = dc & FULL;
        cfg_band = dd & FULL;
        cfg_cal_band = cd & FULL;
        cfg_full_scale = fs & FULL;
    endtask

    function automatic int clip(int v);
        return (v < 0) ? 0 : (v > FULL) ? FULL : v;
    endfunction

    function automatic int pick_sample(int c, int d);
        int v;
        case ($urandom_range(0, 9))
            3, 4: v = c + ($urandom_range(0, 1) ? d : -d) + int'($urandom_range(0, 6)) - 3;
            5: v = c - d + int'($urandom_range(0, 2 * d));
            6: v = $urandom_range(0, 1) ? FULL : 0;
            9: v = c + int'($urandom_range(0, 200)) - 100;
            default: v = $urandom_range(0, FULL);
        endcase
        return clip(v);
    endfunction

    task automatic send_measure();
        int c_x;
        int c_y;
        int d;
        c_x = is_calibrated ? center_x : cfg_center;
        c_y = is_calibrated ? center_y : cfg_center;
        d = is_calibrated ? cfg_cal_band : cfg_band;
        send_item(jcdm_pkg::OP_MEASURE, pick_sample(c_x, d), pick_sample(c_y, d));
    endtask

    task automatic send_cal_samples(input int n);
        int aim_x;
        int aim_y;
        aim_x = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? FULL : 0)
            : $urandom_range(0, FULL);
        aim_y = $urandom_range(0, FULL);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(jcdm_pkg::OP_CAL, $urandom_range(0, FULL), $urandom_range(0, FULL));
            else
                send_item(jcdm_pkg::OP_CAL, clip(aim_x + int'($urandom_range(0, 128)) - 64),
                    clip(aim_y + int'($urandom_range(0, 128)) - 64));
        end
    endtask

    task automatic test_reset_mapping();
        send_item(jcdm_pkg::OP_MEASURE, 2048, 2048);
        send_item(jcdm_pkg::OP_MEASURE, 0, FULL);
        send_item(jcdm_pkg::OP_MEASURE, FULL, 0);
        send_item(jcdm_pkg::OP_MEASURE, 2248, 1848);
        send_item(jcdm_pkg::OP_MEASURE, 2249, 1847);
        send_item(jcdm_pkg::OP_MEASURE, 3000, 1000);
        send_item(jcdm_pkg::OP_CAL, FULL, FULL);
        send_item(OP_UNUSED, FULL, FULL);
        send_item(jcdm_pkg::OP_RESTART, 0, 0);
        send_item(jcdm_pkg::OP_CAL, 0, 0);
        send_item(OP_UNUSED, 1234, 2345);
        send_item(jcdm_pkg::OP_RESTART, FULL, FULL);
    endtask

    task automatic test_span_limits();
        // both spans negative
        load_settings(100, 200, 100, 200);
        send_item(jcdm_pkg::OP_MEASURE, 0, FULL);
        send_item(jcdm_pkg::OP_MEASURE, 50, 350);
        // readings past full scale saturate
        load_settings(1000, 0, 0, 2000);
        send_item(jcdm_pkg::OP_MEASURE, FULL, FULL);
        send_item(jcdm_pkg::OP_MEASURE, 999, 1001);
        send_item(jcdm_pkg::OP_MEASURE, 0, 2001);
        load_settings(0, 0, 0, 0);
        send_item(jcdm_pkg::OP_MEASURE, 0, 0);
        send_item(jcdm_pkg::OP_MEASURE, FULL, 1);
        load_settings(FULL, FULL, FULL, FULL);
        send_item(jcdm_pkg::OP_MEASURE, 0, FULL);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: load_settings(2048, 200, 100, 4095);
                2: load_settings($urandom_range(0, 300), 0, 0, FULL);
                4: load_settings(FULL, FULL, FULL, FULL);
                6: load_settings($urandom_range(1500, 2600), $urandom_range(0, 400), 0, 0);
                default: load_settings($urandom_range(1500, 2600), $urandom_range(0, 400),
                    $urandom_range(0, 300), $urandom_range(3500, FULL));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 87; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 87; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            if (ph % 2 == 1) begin
                if ($urandom_range(0, 1)) send_item(jcdm_pkg::OP_RESTART,
                    $urandom_range(0, FULL), $urandom_range(0, FULL));
                send_cal_samples(CAL_RUN);
            end else begin
                send_cal_samples($urandom_range(5, 40));
                if ($urandom_range(0, 1)) send_item(jcdm_pkg::OP_RESTART, 0, 0);
            end
            for (int i = 0; i < 60; i++) begin
                case ($urandom_range(0, 19))
                    16, 17: send_item(jcdm_pkg::OP_CAL, $urandom_range(0, FULL),
                        $urandom_range(0, FULL));
                    18: send_item(jcdm_pkg::OP_RESTART, $urandom_range(0, FULL),
                        $urandom_range(0, FULL));
                    19: send_item(OP_UNUSED, $urandom_range(0, FULL), $urandom_range(0, FULL));
                    default: send_measure();
                endcase
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_mapping();
        test_span_limits();
        test_random_phases();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d items (%0d measures), checked %0d result beats", items_sent,
            measure_count, beats_checked);
        $display("Completed %0d calibration runs over 8 register settings and 4 throttle modes",
            runs_completed);
        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
